// ----- rtl/core/mfcr_pkg.sv -----
// Shared types and constants for the management frame capture ring.
// No dependencies; used by mfcr_hdr_asm and mgmt_frame_capture_ring.
package mfcr_pkg;

   // One captured header record (196 bits)
   typedef struct packed {
      logic [3:0]         subtype;
      logic [3:0]         channel;
      logic signed [7:0]  rssi;
      logic [11:0]        seq_num;
      logic [47:0]        addr1;
      logic [47:0]        addr2;
      logic [47:0]        addr3;
      logic [11:0]        on_air_len;
      logic [11:0]        snap_len;
   } rec_type;

   // Events raised by the header assembler for the ring control
   typedef struct packed {
      logic commit;
      logic drop;
   } evt_type;

   localparam logic [1:0]  FC_TYPE_MGMT = 2'b00;
   localparam logic [11:0] HDR_LEN      = 12'd24;
   localparam logic [11:0] ADDR1_LO     = 12'd4;
   localparam logic [11:0] ADDR1_HI     = 12'd9;
   localparam logic [11:0] ADDR2_LO     = 12'd10;
   localparam logic [11:0] ADDR2_HI     = 12'd15;
   localparam logic [11:0] ADDR3_LO     = 12'd16;
   localparam logic [11:0] ADDR3_HI     = 12'd21;
   localparam logic [11:0] SEQ_LO_IDX   = 12'd22;
   localparam logic [11:0] SEQ_HI_IDX   = 12'd23;
   localparam logic [11:0] IDX_MAX      = 12'hFFF;

endpackage

// ----- rtl/core/mgmt_frame_capture_ring.sv -----
// Management frame capture ring: filters received management frames, captures
// their header fields into a ring memory and returns the oldest record per pop.
// A pop's response passes through the read stage and then the output register, where a stall holds it.
// Throughput: one request per cycle, frame bytes and pops alike, while rsp_tready is high.
// Reset: synchronous; clears pointers, drop count, mask and capture state, not the ring.
// Depends on mfcr_pkg and mfcr_hdr_asm.
module mgmt_frame_capture_ring #(
   parameter int RING_DEPTH = 32,
   parameter int SNAP_LIMIT = 256
) (
   input  logic         clock,
   input  logic         reset,
   // configuration: want_mask
   input  logic         csr_we,
   input  logic [15:0]  csr_wdata,
   // requests
   input  logic         req_tvalid,
   output logic         req_tready,
   // [7:0] data_byte, [8] first_byte, [9] is_mgmt, [13:10] rx_channel,
   // [21:14] rx_rssi, [33:22] air_len, [39:34] zero
   input  logic [39:0]  req_tdata,
   // [0] func: 0 frame byte, 1 pop
   input  logic         req_tuser,
   input  logic         req_tlast,   // last_byte
   // responses
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [3:0] subtype, [7:4] channel, [15:8] rssi, [27:16] seq_num, [75:28] addr1,
   // [123:76] addr2, [171:124] addr3, [183:172] on_air_len, [195:184] snap_len,
   // [227:196] drop_count, [231:228] zero
   output logic [231:0] rsp_tdata,
   output logic         rsp_tuser    // [0] valid_res
);

   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

   // Configuration register
   logic [15:0] mask_ff;

   // Ring pointers and drop counter
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff, wr_next, rd_next;
   logic [31:0]      drop_ff;
   logic             ring_full, ring_empty;

   // Ring storage, registered read
   mfcr_pkg::rec_type ring_mem [RING_DEPTH];
   mfcr_pkg::rec_type rd_data_ff;
   logic              rd_en;

   // Read stage: record in flight from the ring
   logic        s1_valid_ff, s1_vres_ff;
   logic [31:0] s1_drop_ff;
   logic        s1_adv;

   // Output register
   logic              out_valid_ff, out_vres_ff;
   mfcr_pkg::rec_type out_rec_ff;
   logic [31:0]       out_drop_ff;

   logic              acc, pop_acc, byte_en;
   mfcr_pkg::evt_type evt;
   mfcr_pkg::rec_type cap_rec;

   // Handshake: any request waits only while both stages are full and the output is stalled
   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign acc        = req_tvalid && req_tready;
   assign pop_acc    = acc && req_tuser;
   assign byte_en    = acc && !req_tuser;

   // Wrap pointers at RING_DEPTH, which need not be a power of two
   assign wr_next    = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
   assign rd_next    = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
   assign ring_full  = (wr_next == rd_ptr_ff);
   assign ring_empty = (wr_ptr_ff == rd_ptr_ff);
   assign rd_en      = pop_acc && !ring_empty;

   mfcr_hdr_asm #(
      .SNAP_LIMIT (SNAP_LIMIT)
   ) u_hdr_asm (
      .clock      (clock),
      .reset      (reset),
      .want_mask  (mask_ff),
      .byte_en    (byte_en),
      .data_byte  (req_tdata[7:0]),
      .first_byte (req_tdata[8]),
      .last_byte  (req_tlast),
      .is_mgmt    (req_tdata[9]),
      .rx_channel (req_tdata[13:10]),
      .rx_rssi    (req_tdata[21:14]),
      .air_len    (req_tdata[33:22]),
      .ring_full  (ring_full),
      .evt        (evt),
      .rec        (cap_rec)
   );

   // Ring memory: commit at the write pointer, pop reads at the read pointer.
   // A commit and a pop come from different requests, so they never meet on one entry
   // in the same cycle, and a committed entry is visible to the next pop.
   always_ff @(posedge clock) begin
      if (evt.commit) begin
         ring_mem[wr_ptr_ff] <= cap_rec;
      end
      if (rd_en) begin
         rd_data_ff <= ring_mem[rd_ptr_ff];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff      <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         drop_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            mask_ff <= csr_wdata;
         end
         if (evt.commit) begin
            wr_ptr_ff <= wr_next;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_next;
         end
         // count frames refused for want of space, wrapping
         if (evt.drop) begin
            drop_ff <= drop_ff + 32'd1;
         end
         // advance the read stage
         if (pop_acc) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         // load the output register, or drop it once taken
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: hold the pop outcome and the drop count seen at pop time
   always_ff @(posedge clock) begin
      if (pop_acc) begin
         s1_vres_ff <= !ring_empty;
         s1_drop_ff <= drop_ff;
      end
      if (s1_adv) begin
         out_vres_ff <= s1_vres_ff;
         out_drop_ff <= s1_drop_ff;
         // an empty ring returns an all-zero record
         out_rec_ff  <= s1_vres_ff ? rd_data_ff : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_vres_ff;
   assign rsp_tdata  = {4'b0000,
                        out_drop_ff,
                        out_rec_ff.snap_len,
                        out_rec_ff.on_air_len,
                        out_rec_ff.addr3,
                        out_rec_ff.addr2,
                        out_rec_ff.addr1,
                        out_rec_ff.seq_num,
                        out_rec_ff.rssi,
                        out_rec_ff.channel,
                        out_rec_ff.subtype};

   // A commit never lands on a full ring: pops only free space during a capture
   a_no_commit_full: assert property (@(posedge clock) disable iff (reset)
      evt.commit |-> !ring_full)
      else $error("record committed into a full ring");

   // Pointers stay within the ring
   a_ptr_range: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff <= PTR_LAST) && (rd_ptr_ff <= PTR_LAST))
      else $error("ring pointer out of range");

   // Each drop adds exactly one to the counter
   a_drop_step: assert property (@(posedge clock) disable iff (reset)
      evt.drop |=> drop_ff == $past(drop_ff) + 32'd1)
      else $error("drop count did not advance by one");

   // Both stages full and the output stalled: no further request is taken
   a_stall_backpressure: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_tready) |-> !req_tready)
      else $error("request accepted while the response path is full");

   // A pop on an empty ring yields an all-zero record
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && !s1_vres_ff) |=> (out_rec_ff == '0))
      else $error("empty-ring response carries record data");

endmodule

// ----- rtl/core/mfcr_hdr_asm.sv -----
// Header assembler: filters frames at the first byte and collects header fields.
// Depends on mfcr_pkg (rec_type, evt_type, header byte positions).
module mfcr_hdr_asm #(
   parameter int SNAP_LIMIT = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [15:0]        want_mask,
   input  logic               byte_en,
   input  logic [7:0]         data_byte,
   input  logic               first_byte,
   input  logic               last_byte,
   input  logic               is_mgmt,
   input  logic [3:0]         rx_channel,
   input  logic signed [7:0]  rx_rssi,
   input  logic [11:0]        air_len,
   input  logic               ring_full,
   output mfcr_pkg::evt_type  evt,
   output mfcr_pkg::rec_type  rec
);

   localparam logic [11:0] SNAP_MAX = 12'(SNAP_LIMIT);

   logic              cap_ff, cap_in;
   logic [11:0]       idx_ff, idx_in;
   mfcr_pkg::rec_type rec_ff, rec_in;

   always_comb begin
      cap_in = cap_ff;
      idx_in = idx_ff;
      rec_in = rec_ff;
      evt    = '0;
      if (byte_en) begin
         if (first_byte) begin
            cap_in = 1'b0;
            idx_in = '0;
            if (is_mgmt && data_byte[3:2] == mfcr_pkg::FC_TYPE_MGMT &&
                want_mask[data_byte[7:4]]) begin
               if (ring_full) begin
                  evt.drop = 1'b1;
               end else begin
                  rec_in            = '0;
                  rec_in.subtype    = data_byte[7:4];
                  rec_in.channel    = rx_channel;
                  rec_in.rssi       = rx_rssi;
                  rec_in.on_air_len = air_len;
                  rec_in.snap_len   = (air_len > SNAP_MAX) ? SNAP_MAX : air_len;
                  cap_in            = 1'b1;
                  idx_in            = 12'd1;
               end
            end
         end else if (cap_ff) begin
            // short frames keep all header fields at zero
            if (rec_ff.on_air_len >= mfcr_pkg::HDR_LEN) begin
               if (idx_ff >= mfcr_pkg::ADDR1_LO && idx_ff <= mfcr_pkg::ADDR1_HI) begin
                  rec_in.addr1 = {rec_ff.addr1[39:0], data_byte};
               end else if (idx_ff >= mfcr_pkg::ADDR2_LO &&
                            idx_ff <= mfcr_pkg::ADDR2_HI) begin
                  rec_in.addr2 = {rec_ff.addr2[39:0], data_byte};
               end else if (idx_ff >= mfcr_pkg::ADDR3_LO &&
                            idx_ff <= mfcr_pkg::ADDR3_HI) begin
                  rec_in.addr3 = {rec_ff.addr3[39:0], data_byte};
               end else if (idx_ff == mfcr_pkg::SEQ_LO_IDX) begin
                  rec_in.seq_num = {4'b0000, rec_ff.seq_num[7:4], data_byte[7:4]};
               end else if (idx_ff == mfcr_pkg::SEQ_HI_IDX) begin
                  rec_in.seq_num = {data_byte, rec_ff.seq_num[3:0]};
               end
            end
            if (idx_ff != mfcr_pkg::IDX_MAX) begin
               idx_in = idx_ff + 12'd1;
            end
         end
         if (last_byte && cap_in) begin
            evt.commit = 1'b1;
            cap_in     = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= 1'b0;
         idx_ff <= '0;
         rec_ff <= '0;
      end else begin
         cap_ff <= cap_in;
         idx_ff <= idx_in;
         rec_ff <= rec_in;
      end
   end

   // the committed record includes the byte that closes the frame
   assign rec = rec_in;

endmodule

// ----- sim/mgmt_frame_capture_ring_tb.sv -----
// Testbench for mgmt_frame_capture_ring: drives frame-byte and pop requests,
// predicts every pop reply with a cycle-free shadow of the ring and checks it.
// Depends on mfcr_pkg and the mgmt_frame_capture_ring RTL.
`timescale 1ns / 1ps

module mgmt_frame_capture_ring_tb;

   localparam int RING_DEPTH = 32;
   localparam int SNAP_LIMIT = 256;
   localparam int MAX_PRINTS = 60;

   // one request as the sender sees it, before packing onto the bus
   typedef struct {
      bit                pop;
      logic [7:0]        data;
      bit                first;
      bit                last;
      bit                mgmt;
      logic [3:0]        chan;
      logic signed [7:0] rssi;
      logic [11:0]       alen;
   } req_item_type;

   // what a pop should return
   typedef struct {
      bit                valid;
      mfcr_pkg::rec_type rec;
      logic [31:0]       drops;
   } capture_reply_type;

   logic         clock;
   logic         reset;
   logic         csr_we;
   logic [15:0]  csr_wdata;
   logic         req_tvalid;
   logic         req_tready;
   logic [39:0]  req_tdata;
   logic         req_tuser;
   logic         req_tlast;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [231:0] rsp_tdata;
   logic         rsp_tuser;

   // shadow copy of the block's state
   logic [15:0]       shadow_mask;
   mfcr_pkg::rec_type shadow_ring [RING_DEPTH];
   int                shadow_wr;
   int                shadow_rd;
   logic [31:0]       shadow_drops;
   bit                shadow_capturing;
   logic [11:0]       shadow_idx;
   mfcr_pkg::rec_type shadow_work;

   capture_reply_type pending_replies[$];
   logic [7:0]        frame_bytes[$];
   int                error_count;
   int                midpop_pct;
   int                req_calm;

   mgmt_frame_capture_ring #(
      .RING_DEPTH(RING_DEPTH),
      .SNAP_LIMIT(SNAP_LIMIT)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Hard stop: well beyond the slowest legal run, stalls and gaps included.
   initial begin
      #40_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // ------------------------------------------------------------------
   // Shadow model
   // ------------------------------------------------------------------

   function automatic void shadow_reset();
      shadow_mask      = '0;
      shadow_wr        = 0;
      shadow_rd        = 0;
      shadow_drops     = '0;
      shadow_capturing = 1'b0;
      shadow_idx       = '0;
      shadow_work      = '0;
      foreach (shadow_ring[i]) shadow_ring[i] = '0;
   endfunction

   // Fold one header byte into the working record; short frames keep zeros.
   function automatic void absorb_header_byte(input logic [11:0] idx, input logic [7:0] b);
      if (shadow_work.on_air_len < mfcr_pkg::HDR_LEN) return;
      if (idx >= mfcr_pkg::ADDR1_LO && idx <= mfcr_pkg::ADDR1_HI)
         shadow_work.addr1 = {shadow_work.addr1[39:0], b};
      else if (idx >= mfcr_pkg::ADDR2_LO && idx <= mfcr_pkg::ADDR2_HI)
         shadow_work.addr2 = {shadow_work.addr2[39:0], b};
      else if (idx >= mfcr_pkg::ADDR3_LO && idx <= mfcr_pkg::ADDR3_HI)
         shadow_work.addr3 = {shadow_work.addr3[39:0], b};
      else if (idx == mfcr_pkg::SEQ_LO_IDX)
         shadow_work.seq_num = (shadow_work.seq_num & 12'h0F0) | {8'h00, b[7:4]};
      else if (idx == mfcr_pkg::SEQ_HI_IDX)
         shadow_work.seq_num = (shadow_work.seq_num & 12'h00F) | {b, 4'h0};
   endfunction

   // Advance the shadow by one accepted request; queue a reply for a pop.
   function automatic void predict_request(input req_item_type it);
      capture_reply_type r;
      logic [3:0]        st;
      if (it.pop) begin
         r.valid = 1'b0;
         r.rec   = '0;
         r.drops = shadow_drops;
         if (shadow_rd != shadow_wr) begin
            r.rec     = shadow_ring[shadow_rd];
            r.valid   = 1'b1;
            shadow_rd = (shadow_rd + 1) % RING_DEPTH;
         end
         pending_replies.push_back(r);
         return;
      end
      if (it.first) begin
         // a new first byte always abandons whatever was being collected
         st = it.data[7:4];
         shadow_capturing = 1'b0;
         shadow_idx       = '0;
         if (!it.mgmt || it.data[3:2] != mfcr_pkg::FC_TYPE_MGMT || !shadow_mask[st]) return;
         if ((shadow_wr + 1) % RING_DEPTH == shadow_rd) begin
            shadow_drops = shadow_drops + 32'd1;
            return;
         end
         shadow_work            = '0;
         shadow_work.subtype    = st;
         shadow_work.channel    = it.chan;
         shadow_work.rssi       = it.rssi;
         shadow_work.on_air_len = it.alen;
         shadow_work.snap_len   = (it.alen > SNAP_LIMIT) ? 12'(SNAP_LIMIT) : it.alen;
         shadow_capturing       = 1'b1;
         shadow_idx             = 12'd1;
      end else if (shadow_capturing) begin
         absorb_header_byte(shadow_idx, it.data);
         if (shadow_idx < mfcr_pkg::IDX_MAX) shadow_idx = shadow_idx + 12'd1;
      end else begin
         return;
      end
      if (it.last && shadow_capturing) begin
         shadow_ring[shadow_wr] = shadow_work;
         shadow_wr        = (shadow_wr + 1) % RING_DEPTH;
         shadow_capturing = 1'b0;
      end
   endfunction

   // ------------------------------------------------------------------
   // Reply checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < MAX_PRINTS)
         $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic check_field(input string what, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   task automatic check_reply();
      capture_reply_type e;
      if (pending_replies.size() == 0) begin
         report_mismatch("reply with no pop pending", 64'd1, 64'd0);
         return;
      end
      e = pending_replies.pop_front();
      check_field("valid_res",  64'(rsp_tuser),          64'(e.valid));
      check_field("subtype",    64'(rsp_tdata[3:0]),     64'(e.rec.subtype));
      check_field("channel",    64'(rsp_tdata[7:4]),     64'(e.rec.channel));
      check_field("rssi",       64'(rsp_tdata[15:8]),    64'($unsigned(e.rec.rssi)));
      check_field("seq_num",    64'(rsp_tdata[27:16]),   64'(e.rec.seq_num));
      check_field("addr1",      64'(rsp_tdata[75:28]),   64'(e.rec.addr1));
      check_field("addr2",      64'(rsp_tdata[123:76]),  64'(e.rec.addr2));
      check_field("addr3",      64'(rsp_tdata[171:124]), 64'(e.rec.addr3));
      check_field("on_air_len", 64'(rsp_tdata[183:172]), 64'(e.rec.on_air_len));
      check_field("snap_len",   64'(rsp_tdata[195:184]), 64'(e.rec.snap_len));
      check_field("drop_count", 64'(rsp_tdata[227:196]), 64'(e.drops));
      check_field("padding",    64'(rsp_tdata[231:228]), 64'd0);
   endtask

   // Sample replies at the rising edge, before any of that edge's updates land.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_reply();
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Receiver back-pressure: runs of ready, broken by stalls; some long runs
   // give stretches with no stalling at all.
   initial begin
      int run;
      int stall;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
         repeat (run) begin
            @(negedge clock);
            rsp_tready <= 1'b1;
         end
         stall = pick_gap();
         repeat (stall) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------

   // Present one request after a random gap and hold it until accepted.
   task automatic send_req(input req_item_type it);
      int gap;
      if (req_calm > 0) begin
         req_calm--;
         gap = 0;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 49) == 0) req_calm = $urandom_range(30, 150);
      end
      repeat (gap) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, it.alen, it.rssi, it.chan, it.mgmt, it.first, it.data};
      req_tuser  <= it.pop;
      req_tlast  <= it.last;
      do @(posedge clock); while (!req_tready);
      predict_request(it);
   endtask

   // Every field random; callers override what matters.
   function automatic req_item_type noise_item();
      req_item_type it;
      it.pop   = 1'($urandom_range(0, 1));
      it.data  = 8'($urandom_range(0, 255));
      it.first = 1'($urandom_range(0, 1));
      it.last  = 1'($urandom_range(0, 1));
      it.mgmt  = 1'($urandom_range(0, 1));
      it.chan  = 4'($urandom_range(0, 15));
      it.rssi  = 8'($urandom_range(0, 255));
      it.alen  = 12'($urandom_range(0, 4095));
      return it;
   endfunction

   task automatic send_pop();
      req_item_type it;
      it     = noise_item();
      it.pop = 1'b1;
      send_req(it);
   endtask

   // Send the bytes in frame_bytes as one frame; hold back tlast to truncate it.
   task automatic send_frame(input bit mgmt, input logic [3:0] chan,
                             input logic signed [7:0] rssi, input logic [11:0] alen,
                             input bit with_last);
      req_item_type it;
      for (int i = 0; i < frame_bytes.size(); i++) begin
         if (i > 0 && $urandom_range(0, 99) < midpop_pct) send_pop();
         it       = noise_item();
         it.pop   = 1'b0;
         it.data  = frame_bytes[i];
         it.first = (i == 0);
         it.last  = with_last && (i == frame_bytes.size() - 1);
         if (i == 0) begin
            it.mgmt = mgmt;
            it.chan = chan;
            it.rssi = rssi;
            it.alen = alen;
         end
         send_req(it);
      end
   endtask

   task automatic fill_frame(input logic [7:0] fc, input int len);
      frame_bytes.delete();
      frame_bytes.push_back(fc);
      for (int i = 1; i < len; i++) frame_bytes.push_back(8'($urandom_range(0, 255)));
   endtask

   // Drop valid, let every reply drain, then allow the pipeline to settle.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register write only once the block has gone quiet.
   task automatic write_mask(input logic [15:0] value);
      wait_idle();
      @(negedge clock);
      csr_we      <= 1'b1;
      csr_wdata   <= value;
      shadow_mask  = value;
      @(negedge clock);
      csr_we      <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Mask is zero after reset: pop an empty ring, watch a frame rejected.
   task automatic test_reset_state();
      send_pop();
      fill_frame(8'h80, 1);
      send_frame(1'b1, 4'd1, -8'sd40, 12'd24, 1'b1);
      send_pop();
   endtask

   // Full header at the field extremes; snapshot length clamps.
   task automatic test_header_fields();
      fill_frame(8'hF0, 24);
      frame_bytes[4]  = 8'hFF;
      frame_bytes[9]  = 8'h00;
      frame_bytes[10] = 8'h00;
      frame_bytes[15] = 8'hFF;
      frame_bytes[22] = 8'hFF;
      frame_bytes[23] = 8'hFF;
      send_frame(1'b1, 4'd15, -8'sd128, 12'hFFF, 1'b1);
      send_pop();
   endtask

   // Short on-air length zeroes the header; an early end leaves a partial one.
   task automatic test_short_frames();
      fill_frame(8'h00, 24);
      send_frame(1'b1, 4'd0, 8'sd127, 12'd23, 1'b1);
      fill_frame(8'h10, 13);
      send_frame(1'b1, 4'd7, 8'sd0, 12'd300, 1'b1);
      fill_frame(8'h40, 1);
      send_frame(1'b1, 4'd3, -8'sd1, 12'd0, 1'b1);
      send_pop();
      send_pop();
      send_pop();
   endtask

   // A first byte mid-frame abandons the old frame; stray bytes are ignored.
   task automatic test_abandon_and_strays();
      req_item_type it;
      fill_frame(8'h80, 6);
      send_frame(1'b1, 4'd2, -8'sd60, 12'd60, 1'b0);
      fill_frame(8'h50, 3);
      send_frame(1'b1, 4'd9, -8'sd70, 12'd3, 1'b1);
      it       = noise_item();
      it.pop   = 1'b0;
      it.first = 1'b0;
      it.last  = 1'b1;
      send_req(it);
      send_pop();
      send_pop();
   endtask

   // Not management, nonzero type bits, subtype masked off.
   task automatic test_rejects();
      fill_frame(8'h80, 2);
      send_frame(1'b0, 4'd1, 8'sd0, 12'd2, 1'b1);
      fill_frame(8'h84, 1);
      send_frame(1'b1, 4'd1, 8'sd0, 12'd1, 1'b1);
      fill_frame(8'h88, 1);
      send_frame(1'b1, 4'd1, 8'sd0, 12'd1, 1'b1);
      fill_frame(8'h8C, 1);
      send_frame(1'b1, 4'd1, 8'sd0, 12'd1, 1'b1);
      write_mask(16'h0001);
      fill_frame(8'h10, 1);
      send_frame(1'b1, 4'd4, 8'sd5, 12'd1, 1'b1);
      fill_frame(8'h03, 1);
      send_frame(1'b1, 4'd5, 8'sd6, 12'd1, 1'b1);
      send_pop();
      send_pop();
   endtask

   // Overfill the ring so frames are dropped, then drain past empty.
   task automatic test_ring_full();
      repeat (RING_DEPTH + 2) begin
         fill_frame({4'($urandom_range(0, 15)), mfcr_pkg::FC_TYPE_MGMT,
                     2'($urandom_range(0, 3))}, 1);
         send_frame(1'b1, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
                    12'($urandom_range(0, 4095)), 1'b1);
      end
      repeat (RING_DEPTH + 1) send_pop();
   endtask

   // Frame long enough to saturate the byte counter.
   task automatic test_long_frame();
      fill_frame(8'hB0, 4100);
      send_frame(1'b1, 4'd6, -8'sd90, 12'hFFF, 1'b1);
      send_pop();
   endtask

   // Mostly well-formed frames with random content, mixed with pops,
   // truncated frames, odd headers and stray bytes.
   task automatic test_random(input int n_items, input int pop_pct);
      req_item_type it;
      int           count;
      int           r;
      int           len;
      logic [1:0]   ftype;
      logic [11:0]  alen;
      bit           mgmt;
      count = 0;
      while (count < n_items) begin
         r = $urandom_range(0, 99);
         if (r < pop_pct) begin
            send_pop();
            count++;
         end else if (r < pop_pct + 4) begin
            it       = noise_item();
            it.pop   = 1'b0;
            it.first = 1'b0;
            send_req(it);
         end else begin
            r   = $urandom_range(0, 99);
            len = (r < 15) ? $urandom_range(1, 23) :
                  (r < 90) ? $urandom_range(24, 40) : $urandom_range(41, 300);
            ftype = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(1, 3))
                                                : mfcr_pkg::FC_TYPE_MGMT;
            fill_frame({4'($urandom_range(0, 15)), ftype, 2'($urandom_range(0, 3))}, len);
            r    = $urandom_range(0, 99);
            alen = (r < 60) ? 12'(len) :
                   (r < 80) ? 12'($urandom_range(0, 4095)) : 12'($urandom_range(0, 30));
            mgmt = ($urandom_range(0, 9) != 0);
            send_frame(mgmt, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)), alen,
                       $urandom_range(0, 99) >= 8);
            count += len;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------

   initial begin
      int waited;
      reset       = 1'b1;
      csr_we      = 1'b0;
      csr_wdata   = '0;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = 1'b0;
      req_tlast   = 1'b0;
      error_count = 0;
      midpop_pct  = 0;
      req_calm    = 0;
      shadow_reset();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_state();
      write_mask(16'hFFFF);
      test_header_fields();
      test_short_frames();
      test_abandon_and_strays();
      test_rejects();
      write_mask(16'hFFFF);
      test_ring_full();
      test_long_frame();

      // random phases: masks from empty to full, pop rates that fill and drain
      midpop_pct = 2;
      write_mask(16'hFFFF);
      test_random(300, 20);
      write_mask(16'($urandom_range(0, 65535)));
      test_random(250, 3);
      write_mask(16'hAAAA);
      test_random(200, 40);
      write_mask(16'h5555);
      test_random(200, 10);
      write_mask(16'h0000);
      test_random(100, 25);
      write_mask(16'($urandom_range(0, 65535)));
      test_random(200, 15);
      write_mask(16'hFFFF);
      test_random(250, 5);
      test_random(150, 60);

      // hold valid low and let the last replies drain
      @(negedge clock);
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_replies.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (10) @(posedge clock);
      if (pending_replies.size() != 0)
         report_mismatch("replies never delivered", 64'(pending_replies.size()), 64'd0);

      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- mgmt_frame_capture_ring.f -----
rtl/core/mfcr_pkg.sv
rtl/core/mfcr_hdr_asm.sv
rtl/core/mgmt_frame_capture_ring.sv
sim/mgmt_frame_capture_ring_tb.sv
